[design/ffra_pkg.sv]
package ffra_pkg;

    // free list geometry
    localparam int FREE_ENTRIES = 64;
    localparam int IDX_W        = $clog2(FREE_ENTRIES);
    localparam int CNT_W        = $clog2(FREE_ENTRIES + 1);

    // vertex space limits
    localparam logic [32:0] INITIAL_VERTICES = 33'd1048576;
    localparam logic [32:0] MAX_VERTICES     = 33'h1_0000_0000;
    localparam logic [32:0] SPACE_TOP        = 33'h1_0000_0000;
    localparam logic [32:0] SIZE_MAX32       = 33'h0_FFFF_FFFF;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZERO      = 2'd1;
    localparam logic [1:0] ST_LIST_FULL = 2'd2;
    localparam logic [1:0] ST_EXHAUSTED = 2'd3;

    // opcode values
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // read address select
    typedef enum logic [2:0] {
        RD_HOLD,
        RD_ZERO,
        RD_INC,
        RD_DEC,
        RD_POSP1,
        RD_LAST
    } rd_sel_t;

    // write select
    typedef enum logic [2:0] {
        WR_NONE,
        WR_SPLIT,
        WR_DOWN,
        WR_UP,
        WR_BOTH,
        WR_PREV,
        WR_NEXT,
        WR_INS
    } wr_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic       latch;
        rd_sel_t    rd_sel;
        wr_sel_t    wr_sel;
        logic       prev_capture;
        logic       pos_capture;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       set_status;
        logic [1:0] status_code;
        logic       set_hit_base;
        logic       grow_start;
        logic       grow_step;
        logic       bump_commit;
        logic       cap_commit;
        logic       out_load;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic cnt_zero;
        logic op_free;
        logic idx_lt_n;
        logic hit;
        logic exact;
        logic base_le;
        logic need_over_max;
        logic need_gt_cap;
        logic grow_done;
        logic m_both;
        logic m_prev;
        logic m_next;
        logic list_full;
        logic idx_eq_pos;
    } stat_t;

endpackage

[design/first_fit_region_allocator_core.sv]
// the scan and the shift pass together walk the list of stored entries once
// an allocate that bumps the limit first scans all stored entries, then may double the
// capacity step by step until the need fits
// throughput: one item at a time, set by the single read and write port of the free list memory
// an output register lets a new item start while the last result waits to be taken
// reset clears entry count and bump limit and loads the initial capacity; memory is not cleared
module first_fit_region_allocator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [31:0] region_base,
    input  logic [31:0] run_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] alloc_base,
    output logic [1:0]  status,
    output logic        grew,
    output logic [32:0] capacity_now
);

    ffra_pkg::cmd_t  cmd;
    ffra_pkg::stat_t stat;

    // sequencer
    ffra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // free list, limits and result registers
    ffra_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .opcode       (opcode),
        .region_base  (region_base),
        .run_length   (run_length),
        .alloc_base   (alloc_base),
        .status       (status),
        .grew         (grew),
        .capacity_now (capacity_now)
    );

endmodule

[design/ffra_datapath.sv]
module ffra_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  ffra_pkg::cmd_t      cmd,
    output ffra_pkg::stat_t     stat,
    input  logic                opcode,
    input  logic [31:0]         region_base,
    input  logic [31:0]         run_length,
    output logic [31:0]         alloc_base,
    output logic [1:0]          status,
    output logic                grew,
    output logic [32:0]         capacity_now
);

    // free list memory
    logic [31:0] base_mem [ffra_pkg::FREE_ENTRIES];
    logic [31:0] size_mem [ffra_pkg::FREE_ENTRIES];

    logic                       op_reg;
    logic [31:0]                base_reg;
    logic [31:0]                vcnt_reg;
    logic                       zero_reg;
    logic [ffra_pkg::CNT_W-1:0] cnt_reg;
    logic [32:0]                bump_reg;
    logic [32:0]                cap_reg;
    logic [33:0]                work_reg;
    logic [ffra_pkg::CNT_W-1:0] idx_reg;
    logic [ffra_pkg::CNT_W-1:0] pos_reg;
    logic [31:0]                rbase_reg;
    logic [31:0]                rsize_reg;
    logic [31:0]                pbase_reg;
    logic [31:0]                psize_reg;
    logic                       have_prev_reg;
    logic [31:0]                res_base_reg;
    logic [1:0]                 res_status_reg;
    logic                       res_grew_reg;
    logic [31:0]                out_base_reg;
    logic [1:0]                 out_status_reg;
    logic                       out_grew_reg;
    logic [32:0]                out_cap_reg;

    logic [32:0]                in_sum;
    logic [31:0]                clip_cnt;
    logic [32:0]                need;
    logic [33:0]                total;
    logic                       mprev;
    logic                       mnext;
    logic [ffra_pkg::CNT_W-1:0] rd_addr;
    logic                       rd_en;
    logic [ffra_pkg::CNT_W-1:0] wr_addr;
    logic [31:0]                wr_base;
    logic [31:0]                wr_size;
    logic                       wr_en;

    // clip a freed run at the top of the space
    assign in_sum = {1'b0, region_base} + {1'b0, run_length};
    always_comb
    begin
        if ((opcode == ffra_pkg::OP_FREE) && (in_sum > ffra_pkg::SPACE_TOP))
        begin
            clip_cnt = 32'(ffra_pkg::SPACE_TOP - {1'b0, region_base});
        end
        else
        begin
            clip_cnt = run_length;
        end
    end

    // bump and merge arithmetic
    assign need  = bump_reg + {1'b0, vcnt_reg};
    assign total = {2'b0, psize_reg} + {2'b0, vcnt_reg} + {2'b0, rsize_reg};
    assign mprev = have_prev_reg
                && (({1'b0, pbase_reg} + {1'b0, psize_reg}) == {1'b0, base_reg})
                && (({1'b0, psize_reg} + {1'b0, vcnt_reg}) <= ffra_pkg::SIZE_MAX32);
    assign mnext = (idx_reg < cnt_reg)
                && (({1'b0, base_reg} + {1'b0, vcnt_reg}) == {1'b0, rbase_reg})
                && (({1'b0, rsize_reg} + {1'b0, vcnt_reg}) <= ffra_pkg::SIZE_MAX32);

    // status to controller
    always_comb
    begin
        stat.cnt_zero      = zero_reg;
        stat.op_free       = (op_reg == ffra_pkg::OP_FREE);
        stat.idx_lt_n      = (idx_reg < cnt_reg);
        stat.hit           = (rsize_reg >= vcnt_reg);
        stat.exact         = (rsize_reg == vcnt_reg);
        stat.base_le       = (rbase_reg <= base_reg);
        stat.need_over_max = (need > ffra_pkg::MAX_VERTICES);
        stat.need_gt_cap   = (need > cap_reg);
        stat.grow_done     = (work_reg >= {1'b0, need});
        stat.m_both        = mprev && mnext && (total <= {1'b0, ffra_pkg::SIZE_MAX32});
        stat.m_prev        = mprev;
        stat.m_next        = mnext;
        stat.list_full     = (cnt_reg >= ffra_pkg::CNT_W'(ffra_pkg::FREE_ENTRIES));
        stat.idx_eq_pos    = (idx_reg == pos_reg);
    end

    // read address
    always_comb
    begin
        rd_en = 1'b1;
        case (cmd.rd_sel)
            ffra_pkg::RD_ZERO:  rd_addr = '0;
            ffra_pkg::RD_INC:   rd_addr = idx_reg + 1'b1;
            ffra_pkg::RD_DEC:   rd_addr = idx_reg - 1'b1;
            ffra_pkg::RD_POSP1: rd_addr = pos_reg + 1'b1;
            ffra_pkg::RD_LAST:  rd_addr = cnt_reg - 1'b1;
            default:
            begin
                rd_addr = idx_reg;
                rd_en   = 1'b0;
            end
        endcase
    end

    // write address and data
    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = idx_reg;
        wr_base = rbase_reg;
        wr_size = rsize_reg;
        case (cmd.wr_sel)
            ffra_pkg::WR_SPLIT:
            begin
                wr_base = rbase_reg + vcnt_reg;
                wr_size = rsize_reg - vcnt_reg;
            end
            ffra_pkg::WR_DOWN: wr_addr = idx_reg - 1'b1;
            ffra_pkg::WR_UP:   wr_addr = idx_reg + 1'b1;
            ffra_pkg::WR_BOTH:
            begin
                wr_addr = pos_reg - 1'b1;
                wr_base = pbase_reg;
                wr_size = total[31:0];
            end
            ffra_pkg::WR_PREV:
            begin
                wr_addr = pos_reg - 1'b1;
                wr_base = pbase_reg;
                wr_size = psize_reg + vcnt_reg;
            end
            ffra_pkg::WR_NEXT:
            begin
                wr_addr = pos_reg;
                wr_base = base_reg;
                wr_size = rsize_reg + vcnt_reg;
            end
            ffra_pkg::WR_INS:
            begin
                wr_addr = pos_reg;
                wr_base = base_reg;
                wr_size = vcnt_reg;
            end
            default: wr_en = 1'b0;
        endcase
    end

    // memory ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            base_mem[wr_addr[ffra_pkg::IDX_W-1:0]] <= wr_base;
            size_mem[wr_addr[ffra_pkg::IDX_W-1:0]] <= wr_size;
        end
        if (rd_en)
        begin
            rbase_reg <= base_mem[rd_addr[ffra_pkg::IDX_W-1:0]];
            rsize_reg <= size_mem[rd_addr[ffra_pkg::IDX_W-1:0]];
        end
    end

    // control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            bump_reg      <= '0;
            cap_reg       <= ffra_pkg::INITIAL_VERTICES;
            idx_reg       <= '0;
            pos_reg       <= '0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                idx_reg <= rd_addr;
            end
            if (cmd.pos_capture)
            begin
                pos_reg <= idx_reg;
            end
            if (cmd.latch)
            begin
                have_prev_reg <= 1'b0;
            end
            else if (cmd.prev_capture)
            begin
                have_prev_reg <= 1'b1;
            end
            if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (cmd.cnt_dec)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (cmd.bump_commit)
            begin
                bump_reg <= need;
            end
            if (cmd.cap_commit)
            begin
                cap_reg <= (work_reg > {1'b0, ffra_pkg::MAX_VERTICES})
                         ? ffra_pkg::MAX_VERTICES : work_reg[32:0];
            end
        end
    end

    // operands, work registers and results
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg         <= opcode;
            base_reg       <= region_base;
            vcnt_reg       <= clip_cnt;
            zero_reg       <= (run_length == 32'd0);
            res_base_reg   <= '0;
            res_status_reg <= ffra_pkg::ST_OK;
            res_grew_reg   <= 1'b0;
        end
        if (cmd.prev_capture)
        begin
            pbase_reg <= rbase_reg;
            psize_reg <= rsize_reg;
        end
        if (cmd.set_status)
        begin
            res_status_reg <= cmd.status_code;
        end
        if (cmd.set_hit_base)
        begin
            res_base_reg <= rbase_reg;
        end
        if (cmd.grow_start)
        begin
            work_reg <= (cap_reg == 33'd0) ? 34'd1 : {1'b0, cap_reg};
        end
        else if (cmd.grow_step)
        begin
            work_reg <= {work_reg[32:0], 1'b0};
        end
        if (cmd.bump_commit)
        begin
            res_base_reg <= bump_reg[31:0];
        end
        if (cmd.cap_commit)
        begin
            res_grew_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            out_base_reg   <= res_base_reg;
            out_status_reg <= res_status_reg;
            out_grew_reg   <= res_grew_reg;
            out_cap_reg    <= cap_reg;
        end
    end

    assign alloc_base   = out_base_reg;
    assign status       = out_status_reg;
    assign grew         = out_grew_reg;
    assign capacity_now = out_cap_reg;

    // bookkeeping invariants
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= ffra_pkg::CNT_W'(ffra_pkg::FREE_ENTRIES))
        else $error("free entry count past list depth");
    a_bump_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        bump_reg <= cap_reg)
        else $error("bump limit past capacity");
    a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
        cap_reg <= ffra_pkg::MAX_VERTICES && cap_reg != 33'd0)
        else $error("capacity out of range");

endmodule

[design/ffra_ctrl.sv]
module ffra_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  ffra_pkg::stat_t   stat,
    output ffra_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_ASCAN,
        S_SHDN,
        S_BUMP,
        S_GROW,
        S_FSCAN,
        S_FDEC,
        S_SHUP,
        S_INS,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        cmd.latch        = 1'b0;
        cmd.rd_sel       = ffra_pkg::RD_HOLD;
        cmd.wr_sel       = ffra_pkg::WR_NONE;
        cmd.prev_capture = 1'b0;
        cmd.pos_capture  = 1'b0;
        cmd.cnt_inc      = 1'b0;
        cmd.cnt_dec      = 1'b0;
        cmd.set_status   = 1'b0;
        cmd.status_code  = ffra_pkg::ST_OK;
        cmd.set_hit_base = 1'b0;
        cmd.grow_start   = 1'b0;
        cmd.grow_step    = 1'b0;
        cmd.bump_commit  = 1'b0;
        cmd.cap_commit   = 1'b0;
        cmd.out_load     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    cmd.rd_sel = ffra_pkg::RD_ZERO;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.cnt_zero)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ffra_pkg::ST_ZERO;
                    state_next      = S_DONE;
                end
                else if (stat.op_free)
                begin
                    state_next = S_FSCAN;
                end
                else
                begin
                    state_next = S_ASCAN;
                end
            end
            // first fit scan, one entry per cycle
            S_ASCAN:
            begin
                if (stat.idx_lt_n && stat.hit)
                begin
                    cmd.set_hit_base = 1'b1;
                    if (stat.exact)
                    begin
                        cmd.rd_sel = ffra_pkg::RD_INC;
                        state_next = S_SHDN;
                    end
                    else
                    begin
                        cmd.wr_sel = ffra_pkg::WR_SPLIT;
                        state_next = S_DONE;
                    end
                end
                else if (stat.idx_lt_n)
                begin
                    cmd.rd_sel = ffra_pkg::RD_INC;
                end
                else
                begin
                    state_next = S_BUMP;
                end
            end
            // close the gap left by a removed entry
            S_SHDN:
            begin
                if (stat.idx_lt_n)
                begin
                    cmd.wr_sel = ffra_pkg::WR_DOWN;
                    cmd.rd_sel = ffra_pkg::RD_INC;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_BUMP:
            begin
                if (stat.need_over_max)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ffra_pkg::ST_EXHAUSTED;
                    state_next      = S_DONE;
                end
                else if (stat.need_gt_cap)
                begin
                    cmd.grow_start = 1'b1;
                    state_next     = S_GROW;
                end
                else
                begin
                    cmd.bump_commit = 1'b1;
                    state_next      = S_DONE;
                end
            end
            // one capacity doubling per cycle
            S_GROW:
            begin
                if (stat.grow_done)
                begin
                    cmd.bump_commit = 1'b1;
                    cmd.cap_commit  = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.grow_step = 1'b1;
                end
            end
            // find insert position, keeping the last entry at or below base
            S_FSCAN:
            begin
                if (stat.idx_lt_n && stat.base_le)
                begin
                    cmd.prev_capture = 1'b1;
                    cmd.rd_sel       = ffra_pkg::RD_INC;
                end
                else
                begin
                    cmd.pos_capture = 1'b1;
                    state_next      = S_FDEC;
                end
            end
            S_FDEC:
            begin
                if (stat.m_both)
                begin
                    cmd.wr_sel = ffra_pkg::WR_BOTH;
                    cmd.rd_sel = ffra_pkg::RD_POSP1;
                    state_next = S_SHDN;
                end
                else if (stat.m_prev)
                begin
                    cmd.wr_sel = ffra_pkg::WR_PREV;
                    state_next = S_DONE;
                end
                else if (stat.m_next)
                begin
                    cmd.wr_sel = ffra_pkg::WR_NEXT;
                    state_next = S_DONE;
                end
                else if (stat.list_full)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ffra_pkg::ST_LIST_FULL;
                    state_next      = S_DONE;
                end
                else if (stat.idx_lt_n)
                begin
                    cmd.rd_sel = ffra_pkg::RD_LAST;
                    state_next = S_SHUP;
                end
                else
                begin
                    state_next = S_INS;
                end
            end
            // open a slot at the insert position, top entry first
            S_SHUP:
            begin
                cmd.wr_sel = ffra_pkg::WR_UP;
                if (stat.idx_eq_pos)
                begin
                    state_next = S_INS;
                end
                else
                begin
                    cmd.rd_sel = ffra_pkg::RD_DEC;
                end
            end
            S_INS:
            begin
                cmd.wr_sel  = ffra_pkg::WR_INS;
                cmd.cnt_inc = 1'b1;
                state_next  = S_DONE;
            end
            // hand the result to the output register
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result loads only when the output slot is free
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwrote a pending item");
    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not shown");
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (cmd.wr_sel == ffra_pkg::WR_NONE))
        else $error("free list written while idle");

endmodule

[test/first_fit_region_allocator_checker.sv]
`timescale 1ns / 1ps

module first_fit_region_allocator_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        opcode,
    input  logic [31:0] region_base,
    input  logic [31:0] run_length,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] alloc_base,
    input  logic [1:0]  status,
    input  logic        grew,
    input  logic [32:0] capacity_now,
    output int          failures,
    output int          pending
);

    typedef struct {
        logic [31:0] base;
        logic [1:0]  st;
        logic        grew;
        logic [32:0] cap;
    } grant_t;

    // shadow of the allocator state
    longint unsigned run_base [ffra_pkg::FREE_ENTRIES];
    longint unsigned run_size [ffra_pkg::FREE_ENTRIES];
    int              run_count;
    longint unsigned bump_mark;
    longint unsigned space_cap;

    grant_t grant_queue [$];

    function automatic void drop_run(input int at);
        int k;
        for (k = at; k + 1 < run_count; k++)
        begin
            run_base[k] = run_base[k + 1];
            run_size[k] = run_size[k + 1];
        end
        run_count--;
    endfunction

    function automatic void allocate_run(input longint unsigned c, inout grant_t g);
        bit              found;
        longint unsigned need;
        longint unsigned nc;
        found = 0;
        // first fit over the sorted free runs
        for (int i = 0; i < run_count; i++)
        begin
            if (run_size[i] >= c)
            begin
                found  = 1;
                g.base = run_base[i][31:0];
                if (run_size[i] == c)
                    drop_run(i);
                else
                begin
                    run_base[i] = (run_base[i] + c) & ffra_pkg::SIZE_MAX32;
                    run_size[i] = run_size[i] - c;
                end
                break;
            end
        end
        // no run fits: bump the limit, growing as needed
        if (!found)
        begin
            need = bump_mark + c;
            if (need > ffra_pkg::MAX_VERTICES)
                g.st = ffra_pkg::ST_EXHAUSTED;
            else
            begin
                if (need > space_cap)
                begin
                    nc = (space_cap != 0) ? space_cap : 1;
                    while (nc < need)
                        nc = nc << 1;
                    if (nc > ffra_pkg::MAX_VERTICES)
                        nc = ffra_pkg::MAX_VERTICES;
                    space_cap = nc;
                    g.grew    = 1'b1;
                end
                g.base    = bump_mark[31:0];
                bump_mark = need;
            end
        end
    endfunction

    function automatic void release_run(input longint unsigned b, input longint unsigned c,
                                        inout grant_t g);
        int  pos;
        bit  mprev;
        bit  mnext;
        // clip a run that passes the top of the space
        if (b + c > ffra_pkg::SPACE_TOP)
            c = ffra_pkg::SPACE_TOP - b;
        pos   = 0;
        mprev = 0;
        mnext = 0;
        while (pos < run_count && run_base[pos] <= b)
            pos++;
        if (pos > 0)
            mprev = (run_base[pos - 1] + run_size[pos - 1] == b) &&
                    (run_size[pos - 1] + c <= ffra_pkg::SIZE_MAX32);
        if (pos < run_count)
            mnext = (b + c == run_base[pos]) &&
                    (run_size[pos] + c <= ffra_pkg::SIZE_MAX32);
        if (mprev && mnext &&
            (run_size[pos - 1] + c + run_size[pos] > ffra_pkg::SIZE_MAX32))
            mnext = 0;
        // merge, insert or drop
        if (mprev && mnext)
        begin
            run_size[pos - 1] = run_size[pos - 1] + c + run_size[pos];
            drop_run(pos);
        end
        else if (mprev)
            run_size[pos - 1] = run_size[pos - 1] + c;
        else if (mnext)
        begin
            run_base[pos] = b;
            run_size[pos] = run_size[pos] + c;
        end
        else if (run_count >= ffra_pkg::FREE_ENTRIES)
            g.st = ffra_pkg::ST_LIST_FULL;
        else
        begin
            for (int k = run_count; k > pos; k--)
            begin
                run_base[k] = run_base[k - 1];
                run_size[k] = run_size[k - 1];
            end
            run_base[pos] = b;
            run_size[pos] = c;
            run_count++;
        end
    endfunction

    function automatic grant_t predict_grant(input logic op, input logic [31:0] b,
                                             input logic [31:0] c);
        grant_t g;
        g.base = '0;
        g.st   = ffra_pkg::ST_OK;
        g.grew = 1'b0;
        if (c == 0)
            g.st = ffra_pkg::ST_ZERO;
        else if (op == ffra_pkg::OP_ALLOC)
            allocate_run(longint'(c), g);
        else
            release_run(longint'(b), longint'(c), g);
        g.cap = space_cap[32:0];
        return g;
    endfunction

    assign pending = grant_queue.size();

    // predict on accepted items, compare accepted results
    always @(posedge clk or negedge rst_n)
    begin
        grant_t exp_g;
        if (!rst_n)
        begin
            run_count = 0;
            bump_mark = 0;
            space_cap = ffra_pkg::INITIAL_VERTICES;
            grant_queue.delete();
            failures  = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                grant_queue.insert(grant_queue.size(),
                                   predict_grant(opcode, region_base, run_length));
            if (out_valid && out_ready)
            begin
                if (grant_queue.size() == 0)
                begin
                    $error("result with no item pending");
                    failures++;
                end
                else
                begin
                    exp_g = grant_queue.pop_front();
                    if (alloc_base !== exp_g.base)
                    begin
                        $error("alloc_base expected %h got %h", exp_g.base, alloc_base);
                        failures++;
                    end
                    if (status !== exp_g.st)
                    begin
                        $error("status expected %0d got %0d", exp_g.st, status);
                        failures++;
                    end
                    if (grew !== exp_g.grew)
                    begin
                        $error("grew expected %0b got %0b", exp_g.grew, grew);
                        failures++;
                    end
                    if (capacity_now !== exp_g.cap)
                    begin
                        $error("capacity_now expected %h got %h", exp_g.cap, capacity_now);
                        failures++;
                    end
                end
            end
        end
    end

endmodule

[test/tb_first_fit_region_allocator_core.sv]
`timescale 1ns / 1ps

module tb_first_fit_region_allocator_core;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        opcode = ffra_pkg::OP_ALLOC;
    logic [31:0] region_base = '0;
    logic [31:0] run_length = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] alloc_base;
    logic [1:0]  status;
    logic        grew;
    logic [32:0] capacity_now;
    int          failures;
    int          pending;

    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_cycles = 0;
    logic [31:0] last_base = 32'd4096;
    logic [31:0] last_count = 32'd8;

    first_fit_region_allocator_core u_top (.*);

    first_fit_region_allocator_checker u_checker (.*);

    always #5 clk = ~clk;

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles--;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        #30_000_000;
        $display("first_fit_region_allocator_core: mismatch");
        $finish;
    end

    task automatic send_item(input logic op, input logic [31:0] b, input logic [31:0] c);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        region_base <= b;
        run_length  <= c;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
    endtask

    task automatic send_random_item();
        int          r;
        logic [31:0] c;
        logic [31:0] b;
        r = $urandom_range(99);
        c = ($urandom_range(9) < 8) ? $urandom_range(1, 64) : $urandom_range(1, 4096);
        if (r < 40)
        begin
            // allocate, now and then a large one to force growth
            if ($urandom_range(19) == 0)
                c = $urandom_range(1, 1 << 22);
            send_item(ffra_pkg::OP_ALLOC, $urandom, c);
        end
        else if (r < 75)
        begin
            // free a run touching the previous one, above or below it
            if ($urandom_range(1))
                b = last_base + last_count;
            else
                b = last_base - c;
            last_base  = b;
            last_count = c;
            send_item(ffra_pkg::OP_FREE, b, c);
        end
        else if (r < 95)
        begin
            // scattered free, sometimes huge so that it clips at the top
            b = $urandom;
            if ($urandom_range(9) == 0)
                c = $urandom;
            last_base  = b;
            last_count = c;
            send_item(ffra_pkg::OP_FREE, b, c);
        end
        else
            send_item(1'($urandom_range(1)), $urandom, 32'd0);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero counts
        send_item(ffra_pkg::OP_ALLOC, 32'h0, 32'd0);
        send_item(ffra_pkg::OP_FREE, 32'hFFFF_FFFF, 32'd0);
        // two halves of the space do not merge past the size limit
        send_item(ffra_pkg::OP_FREE, 32'h0, 32'h8000_0000);
        send_item(ffra_pkg::OP_FREE, 32'h8000_0000, 32'h8000_0000);
        send_item(ffra_pkg::OP_ALLOC, 32'h0, 32'h8000_0000);
        send_item(ffra_pkg::OP_ALLOC, 32'h0, 32'h8000_0000);
        // both merges possible but not together; the lower one is taken
        send_item(ffra_pkg::OP_FREE, 32'h0, 32'h4000_0000);
        send_item(ffra_pkg::OP_FREE, 32'h5000_0000, 32'hB000_0000);
        send_item(ffra_pkg::OP_FREE, 32'h4000_0000, 32'h1000_0000);
        send_item(ffra_pkg::OP_ALLOC, 32'h0, 32'hB000_0000);
        send_item(ffra_pkg::OP_ALLOC, 32'h0, 32'h5000_0000);
        // bump allocations, then frees with merges
        send_item(ffra_pkg::OP_ALLOC, 32'h0, 32'd16);
        send_item(ffra_pkg::OP_ALLOC, 32'h0, 32'd16);
        send_item(ffra_pkg::OP_FREE, 32'd0, 32'd16);
        send_item(ffra_pkg::OP_FREE, 32'd16, 32'd16);
        send_item(ffra_pkg::OP_ALLOC, 32'h0, 32'd32);
        send_item(ffra_pkg::OP_FREE, 32'd300, 32'd10);
        send_item(ffra_pkg::OP_FREE, 32'd320, 32'd10);
        send_item(ffra_pkg::OP_FREE, 32'd310, 32'd10);
        send_item(ffra_pkg::OP_FREE, 32'd290, 32'd10);
        // equal bases, split from the front
        send_item(ffra_pkg::OP_FREE, 32'd500, 32'd5);
        send_item(ffra_pkg::OP_FREE, 32'd500, 32'd3);
        send_item(ffra_pkg::OP_ALLOC, 32'h0, 32'd20);
        // run past the top is clipped
        send_item(ffra_pkg::OP_FREE, 32'hFFFF_FFF0, 32'h0000_0100);

        // random phases with different idling
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 71 : 34) : 0;
            stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 71 : 34) : 0;
            repeat (400) send_random_item();
        end

        // long hold-off on the result side while items keep coming
        idle_pct    = 0;
        stall_pct   = 0;
        hold_cycles = 3000;
        repeat (60) send_random_item();

        // growth to the maximum and exhaustion of the space
        send_item(ffra_pkg::OP_ALLOC, 32'h0, 32'h8000_0000);
        send_item(ffra_pkg::OP_ALLOC, 32'h0, 32'h8000_0000);
        send_item(ffra_pkg::OP_ALLOC, 32'h0, 32'hFFFF_FFFF);
        send_item(ffra_pkg::OP_ALLOC, 32'h0, 32'hFFFF_FFFF);
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("first_fit_region_allocator_core: match");
        else
            $display("first_fit_region_allocator_core: mismatch");
        $finish;
    end

endmodule

[first_fit_region_allocator_core.f]
design/ffra_pkg.sv
design/ffra_datapath.sv
design/ffra_ctrl.sv
design/first_fit_region_allocator_core.sv
test/first_fit_region_allocator_checker.sv
test/tb_first_fit_region_allocator_core.sv
